### sv/pgn_pkg.sv
// Package for perlin_gradient_noise: widths, permutation table.
// No dependencies.
`timescale 1ns / 1ps
package pgn_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int NOISE_W       = 20;

    function automatic logic [7:0] perm(input logic [7:0] i);
        logic [7:0] r;
        case (i)
            8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
            8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
            8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
            8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
            8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
            8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
            8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
            8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
            8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
            8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
            8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
            8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
            8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
            8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
            8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
            8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
            8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
            8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
            8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
            8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
            8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
            8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
            8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
            8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
            8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
            8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
            8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
            8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
            8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
            8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
            8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
            8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
            8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
            8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
            8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
            8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
            8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
            8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
            8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
            8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
            8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
            8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
            8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
            8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
            8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
            8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
            8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
            8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
            8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
            8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
            8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
            8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
            8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
            8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
            8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
            8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
            8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
            8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
            8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
            8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
            8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
            8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
            8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
            8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

### sv/perlin_gradient_noise.sv
// Improved gradient noise, 2D/3D, one point per cycle. Throughput is one transfer
// per cycle while the output is not stalled. Stages: fraction/cell split with
// the first hash, second hash round, corner hash, gradients and fade q, two
// fade multiplies, fade done, then one stage each for the x, y and z lerps.
// aresetn (sync, active low) clears all valid bits and sets dimension_mode to 3D.
// Depends on pgn_pkg.
`timescale 1ns / 1ps
module perlin_gradient_noise
    import pgn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,      // dimension_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,          // coord_x [31:0], coord_y [63:32], coord_z [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata           // noise_value [19:0], zero pad [23:20]
);

    localparam int F   = FRAC_BITS;
    localparam int OW  = F + 2;           // corner offset, signed
    localparam int GW  = F + 3;           // gradient, signed
    localparam int NS  = 10;              // pipeline depth
    // Lerp work width: room for the gradients and for the clamp limits.
    localparam int LW  = (F + 5 > NOISE_W + 1) ? F + 5 : NOISE_W + 1;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    // Gradient dot product for the selected dimension.
    function automatic logic signed [GW-1:0] grad(input logic [7:0] h, input logic d3,
        input logic signed [OW-1:0] x, input logic signed [OW-1:0] y,
        input logic signed [OW-1:0] z);
        logic signed [GW-1:0] u, v, xe, ye, ze;
        logic [3:0] hh;
        hh = h[3:0];
        xe = GW'(x); ye = GW'(y); ze = GW'(z);
        if (!d3) begin
            return (h[0] ? xe : -xe) + (h[1] ? ye : -ye);
        end
        u = (hh < 4'd8) ? xe : ye;
        v = (hh < 4'd4) ? ye : ((hh == 4'd12 || hh == 4'd14) ? xe : ze);
        return (hh[0] ? -u : u) + (hh[1] ? -v : v);
    endfunction

    logic dim_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) dim_reg <= 1'b1;
        else if (cfg_wr_en) dim_reg <= cfg_wr_data;
    end

    // Pipeline advance: a stage moves when the output side is not blocked.
    logic [NS-1:0] vld_reg;
    logic          adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[NS-2:0], s_tvalid};
    end

    // Stage 1: split coordinates, first hash.
    logic [F-1:0] fx1_reg, fy1_reg, fz1_reg;
    logic [7:0]   yi1_reg, zi1_reg, pa1_reg, pb1_reg;
    logic         d1_reg;
    // Stage 2: cell hashes a/b rows.
    logic [F-1:0] fx2_reg, fy2_reg, fz2_reg;
    logic [7:0]   zi2_reg, aa2_reg, ab2_reg, ba2_reg, bb2_reg;
    logic         d2_reg;
    // Stage 3: corner hashes.
    logic [F-1:0] fx3_reg, fy3_reg, fz3_reg;
    logic [7:0]   h3_reg [8];
    logic         d3_reg;
    // Stage 4: gradients, fade q values.
    logic signed [GW-1:0] g4_reg [8];
    logic [F+4:0] q4_reg [3];
    logic [F-1:0] f4_reg [3];
    logic         d4_reg;
    // Stages 5-6: fade products.
    logic signed [GW-1:0] g5_reg [8], g6_reg [8];
    logic [F+4:0] r5_reg [3], r6_reg [3];
    logic [F-1:0] f5_reg [3], f6_reg [3];
    logic         d5_reg, d6_reg;
    // Stage 7: fades done.  Stage 8: x lerps.  Stage 9: y lerps.
    // Stage 10: z lerp and clamp.
    logic signed [GW-1:0] g7_reg [8];
    logic [F:0]   u7_reg, v7_reg, w7_reg;
    logic         d7_reg;
    logic signed [LW-1:0] x8_reg [4];
    logic [F:0]   v8_reg, w8_reg;
    logic         d8_reg;
    logic signed [LW-1:0] y9_reg [2];
    logic [F:0]   w9_reg;
    logic         d9_reg;
    logic signed [NOISE_W-1:0] res_reg;

    logic [F-1:0] fx_in, fy_in, fz_in;
    logic [7:0]   xi_in, yi_in, zi_in;
    assign fx_in = s_tdata[F-1:0];
    assign fy_in = s_tdata[32+F-1:32];
    assign fz_in = s_tdata[64+F-1:64];
    assign xi_in = s_tdata[F+7:F];
    assign yi_in = s_tdata[32+F+7:32+F];
    assign zi_in = s_tdata[64+F+7:64+F];

    function automatic logic signed [LW-1:0] lerp(input logic [F:0] t,
        input logic signed [LW-1:0] a, input logic signed [LW-1:0] b);
        logic signed [LW+F+1:0] p;
        p = $signed({1'b0, t}) * (b - a);
        return a + LW'(p >>> F);
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [7:0] a, b, zz;
            logic signed [OW-1:0] ox0, ox1, oy0, oy1, oz0, oz1;
            logic signed [LW-1:0] n;
            fx1_reg <= fx_in; fy1_reg <= fy_in; fz1_reg <= fz_in;
            yi1_reg <= yi_in; zi1_reg <= zi_in; d1_reg <= dim_reg;
            pa1_reg <= perm(xi_in); pb1_reg <= perm(xi_in + 8'd1);

            a = pa1_reg + yi1_reg; b = pb1_reg + yi1_reg;
            fx2_reg <= fx1_reg; fy2_reg <= fy1_reg; fz2_reg <= fz1_reg;
            zi2_reg <= zi1_reg; d2_reg <= d1_reg;
            aa2_reg <= perm(a); ab2_reg <= perm(a + 8'd1);
            ba2_reg <= perm(b); bb2_reg <= perm(b + 8'd1);

            zz = d2_reg ? zi2_reg : 8'd0;
            fx3_reg <= fx2_reg; fy3_reg <= fy2_reg; fz3_reg <= fz2_reg; d3_reg <= d2_reg;
            h3_reg[0] <= perm(aa2_reg + zz); h3_reg[1] <= perm(ba2_reg + zz);
            h3_reg[2] <= perm(ab2_reg + zz); h3_reg[3] <= perm(bb2_reg + zz);
            h3_reg[4] <= perm(aa2_reg + zz + 8'd1); h3_reg[5] <= perm(ba2_reg + zz + 8'd1);
            h3_reg[6] <= perm(ab2_reg + zz + 8'd1); h3_reg[7] <= perm(bb2_reg + zz + 8'd1);

            ox0 = OW'(fx3_reg); ox1 = OW'(fx3_reg) - OW'(ONE);
            oy0 = OW'(fy3_reg); oy1 = OW'(fy3_reg) - OW'(ONE);
            oz0 = OW'(fz3_reg); oz1 = OW'(fz3_reg) - OW'(ONE);
            g4_reg[0] <= grad(h3_reg[0], d3_reg, ox0, oy0, oz0);
            g4_reg[1] <= grad(h3_reg[1], d3_reg, ox1, oy0, oz0);
            g4_reg[2] <= grad(h3_reg[2], d3_reg, ox0, oy1, oz0);
            g4_reg[3] <= grad(h3_reg[3], d3_reg, ox1, oy1, oz0);
            g4_reg[4] <= grad(h3_reg[4], d3_reg, ox0, oy0, oz1);
            g4_reg[5] <= grad(h3_reg[5], d3_reg, ox1, oy0, oz1);
            g4_reg[6] <= grad(h3_reg[6], d3_reg, ox0, oy1, oz1);
            g4_reg[7] <= grad(h3_reg[7], d3_reg, ox1, oy1, oz1);
            f4_reg[0] <= fx3_reg; f4_reg[1] <= fy3_reg; f4_reg[2] <= fz3_reg;
            d4_reg <= d3_reg;
            for (int i = 0; i < 3; i++) begin
                logic [F-1:0] f;
                logic [2*F+2:0] sq;
                f = (i == 0) ? fx3_reg : ((i == 1) ? fy3_reg : fz3_reg);
                sq = (2*F+3)'(6) * f * f;
                q4_reg[i] <= (F+5)'(sq >> F) + (F+5)'(10) * (F+5)'(ONE)
                             - (F+5)'(15) * (F+5)'(f);
            end

            g5_reg <= g4_reg; f5_reg <= f4_reg; d5_reg <= d4_reg;
            for (int i = 0; i < 3; i++)
                r5_reg[i] <= (F+5)'(((2*F+5)'(q4_reg[i]) * f4_reg[i]) >> F);
            g6_reg <= g5_reg; f6_reg <= f5_reg; d6_reg <= d5_reg;
            for (int i = 0; i < 3; i++)
                r6_reg[i] <= (F+5)'(((2*F+5)'(r5_reg[i]) * f5_reg[i]) >> F);

            // Finish the three fades, carry the gradients.
            u7_reg <= (F+1)'(((2*F+5)'(r6_reg[0]) * f6_reg[0]) >> F);
            v7_reg <= (F+1)'(((2*F+5)'(r6_reg[1]) * f6_reg[1]) >> F);
            w7_reg <= (F+1)'(((2*F+5)'(r6_reg[2]) * f6_reg[2]) >> F);
            g7_reg <= g6_reg; d7_reg <= d6_reg;

            // Blend along x.
            for (int k = 0; k < 4; k++)
                x8_reg[k] <= lerp(u7_reg, LW'(g7_reg[2*k]), LW'(g7_reg[2*k+1]));
            v8_reg <= v7_reg; w8_reg <= w7_reg; d8_reg <= d7_reg;

            // Blend along y.
            y9_reg[0] <= lerp(v8_reg, x8_reg[0], x8_reg[1]);
            y9_reg[1] <= lerp(v8_reg, x8_reg[2], x8_reg[3]);
            w9_reg <= w8_reg; d9_reg <= d8_reg;

            // Blend along z in 3D mode, then clamp to the output range.
            n  = d9_reg ? lerp(w9_reg, y9_reg[0], y9_reg[1]) : y9_reg[0];
            if (n > LW'(524287))       res_reg <= 20'sd524287;
            else if (n < -LW'(524288)) res_reg <= -20'sd524288;
            else                       res_reg <= NOISE_W'(n);
        end
    end

    assign m_tdata = {4'd0, res_reg};

    // A held result must not change while the sink stalls.
    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
    endproperty
    a_hold: assert property (p_hold) else $error("result changed under stall");

    property p_ready;
        @(posedge aclk) disable iff (!aresetn) (!m_tvalid) |-> s_tready;
    endproperty
    a_ready: assert property (p_ready) else $error("input blocked with empty output");

    property p_pad;
        @(posedge aclk) disable iff (!aresetn) m_tvalid |-> (m_tdata[23:20] == 4'd0);
    endproperty
    a_pad: assert property (p_pad) else $error("pad bits set");

endmodule
